### rtl/csba_pkg.sv
`default_nettype none
// ============================================================================
// csba_pkg
// Shared types, codes and helper functions of the command slot allocator.
// ============================================================================
package csba_pkg;

    localparam int MAX_SLOTS = 32;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 6;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESET   = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

    localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 6'd32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // apply the operation to the free map
        logic count;  // build the in-flight mask and its population count
    } csba_ctl_t;

    // Effective slot count: zero and values beyond the slot range disable the block.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
        if (cnt == '0 || cnt > CNT_W'(MAX_SLOTS))
            return '0;
        return cnt;
    endfunction

    // Bits below n set, all bits set when n covers the whole map.
    function automatic logic [MAX_SLOTS-1:0] range_mask(input logic [CNT_W-1:0] n);
        logic [MAX_SLOTS-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
            m[i] = (CNT_W'(i) < n);
        return m;
    endfunction

    // Index of the single set bit of a one-hot vector (zero when empty).
    function automatic logic [SLOT_W-1:0] onehot_index(input logic [MAX_SLOTS-1:0] oh);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
            if (oh[i])
                idx = idx | SLOT_W'(i);
        return idx;
    endfunction

    // Population count of a 32-bit word as an adder tree.
    function automatic logic [CNT_W-1:0] popcount32(input logic [31:0] v);
        logic [1:0] l1 [16];
        logic [2:0] l2 [8];
        logic [3:0] l3 [4];
        logic [4:0] l4 [2];
        for (int i = 0; i < 16; i++)
            l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 8; i++)
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 4; i++)
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        for (int i = 0; i < 2; i++)
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        return {1'b0, l4[0]} + {1'b0, l4[1]};
    endfunction

endpackage
`default_nettype wire

### rtl/csba_ctrl.sv
`default_nettype none
// ============================================================================
// csba_ctrl
// Controller of the slot allocator: sequences capture, execute, count and
// response for one item at a time.
// ============================================================================
module csba_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic                    cfg_ready,
    output csba_pkg::csba_ctl_t     ctl
);
    import csba_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_CNT  = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_EXEC;
            end
            S_EXEC: state_next = S_CNT;
            S_CNT:  state_next = S_RESP;
            S_RESP:
            begin
                if (!rsp_stall)
                    state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);
    assign cfg_ready = (state_reg == S_IDLE);

    assign ctl.load  = cmd_valid && (state_reg == S_IDLE);
    assign ctl.exec  = (state_reg == S_EXEC);
    assign ctl.count = (state_reg == S_CNT);

endmodule
`default_nettype wire

### rtl/csba_dpath.sv
`default_nettype none
// ============================================================================
// csba_dpath
// Datapath of the slot allocator: free map, slot count register, lowest
// free slot search and in-flight mask population count.
// ============================================================================
module csba_dpath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire csba_pkg::csba_ctl_t          ctl,
    input  wire logic [csba_pkg::OP_W-1:0]    opcode,
    input  wire logic [csba_pkg::SLOT_W-1:0]  slot,
    input  wire logic                         cfg_we,
    input  wire logic [csba_pkg::CNT_W-1:0]   cfg_data,
    output logic                              status,
    output logic [csba_pkg::SLOT_W-1:0]       granted_slot,
    output logic                              slot_is_free,
    output logic [csba_pkg::MAX_SLOTS-1:0]    busy_map,
    output logic [csba_pkg::CNT_W-1:0]        inflight_count
);
    import csba_pkg::*;

    logic [MAX_SLOTS-1:0] free_map_reg;
    logic [MAX_SLOTS-1:0] free_map_next;
    logic [CNT_W-1:0]     slot_count_reg;
    logic [OP_W-1:0]      op_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [MAX_SLOTS-1:0] valid_reg;
    logic                 status_reg;
    logic                 status_next;
    logic [SLOT_W-1:0]    granted_reg;
    logic [SLOT_W-1:0]    granted_next;
    logic                 is_free_reg;
    logic                 is_free_next;
    logic [MAX_SLOTS-1:0] mask_reg;
    logic [CNT_W-1:0]     count_reg;

    logic [CNT_W-1:0]     n;
    logic [MAX_SLOTS-1:0] valid;
    logic [MAX_SLOTS-1:0] cand;
    logic [MAX_SLOTS-1:0] lowest;
    logic                 out_of_range;
    logic [MAX_SLOTS-1:0] slot_bit;
    logic [MAX_SLOTS-1:0] busy_mask;

    assign n            = eff_count(slot_count_reg);
    assign valid        = range_mask(n);
    assign cand         = free_map_reg & valid;
    // Isolate the lowest set bit of the candidates.
    assign lowest       = cand & (~cand + MAX_SLOTS'(1));
    assign out_of_range = ({1'b0, slot_reg} >= n);
    assign slot_bit     = MAX_SLOTS'(1) << slot_reg;
    assign busy_mask    = valid_reg & ~free_map_reg;

    always_comb
    begin
        free_map_next = free_map_reg;
        status_next   = 1'b0;
        granted_next  = '0;
        is_free_next  = 1'b0;
        unique case (op_reg)
            OP_ALLOC:
            begin
                if (cand == '0)
                    status_next = 1'b1;
                else
                begin
                    granted_next  = onehot_index(lowest);
                    free_map_next = free_map_reg & ~lowest;
                end
            end
            OP_RELEASE:
            begin
                if (out_of_range || free_map_reg[slot_reg])
                    status_next = 1'b1;
                else
                    free_map_next = free_map_reg | slot_bit;
            end
            OP_RESET:
            begin
                if (n == '0)
                    status_next = 1'b1;
                else
                    free_map_next = valid;
            end
            OP_QUERY:
            begin
                if (out_of_range)
                    status_next = 1'b1;
                else
                    is_free_next = free_map_reg[slot_reg];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg   <= '1;
            slot_count_reg <= SLOT_COUNT_RST;
        end
        else
        begin
            if (cfg_we)
                slot_count_reg <= cfg_data;
            if (ctl.exec)
                free_map_reg <= free_map_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg   <= opcode;
            slot_reg <= slot;
        end
        if (ctl.exec)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            is_free_reg <= is_free_next;
            valid_reg   <= valid;
        end
        if (ctl.count)
        begin
            mask_reg  <= busy_mask;
            count_reg <= popcount32(busy_mask);
        end
    end

    assign status         = status_reg;
    assign granted_slot   = granted_reg;
    assign slot_is_free   = is_free_reg;
    assign busy_map       = mask_reg;
    assign inflight_count = count_reg;

endmodule
`default_nettype wire

### rtl/command_slot_bitmap_allocator.sv
`default_nettype none
// ============================================================================
// command_slot_bitmap_allocator
// Command slot allocator over a 32-entry free bitmap.
// ============================================================================
// Usage:
// The command channel (cmd_valid, cmd_stall, opcode, slot) carries one item
// per operation: allocate, release, reset free map or query. The response
// channel (rsp_valid, rsp_stall) returns exactly one item per command with
// status, granted_slot, slot_is_free and the in-flight mask and count.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the slot
// count; it is only written while no command is in progress, and software
// issues a reset-free-map command after changing it.
// Sequence: a captured command updates the free map in the execute state, the
// in-flight mask and its population count are registered in the count state,
// and the response is valid in the response state. One item is handled at a
// time, so no new command is taken until the response was taken; the controller sequence has one state per step.
// While rsp_stall is high the response item is held unchanged and the
// command channel stays stalled. After reset all slots are free and the
// slot count is 32.
// ============================================================================
module command_slot_bitmap_allocator (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    output logic                              cmd_stall,
    input  wire logic [csba_pkg::OP_W-1:0]    opcode,
    input  wire logic [csba_pkg::SLOT_W-1:0]  slot,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic                              status,
    output logic [csba_pkg::SLOT_W-1:0]       granted_slot,
    output logic                              slot_is_free,
    output logic [csba_pkg::MAX_SLOTS-1:0]    busy_map,
    output logic [csba_pkg::CNT_W-1:0]        inflight_count,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [csba_pkg::CNT_W-1:0]   cfg_data
);
    import csba_pkg::*;

    csba_ctl_t ctl;
    logic      cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    // The controller owns the handshakes and steps the datapath.
    csba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_ready (cfg_ready),
        .ctl       (ctl)
    );

    // The datapath holds the free map and builds every response field.
    csba_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .opcode         (opcode),
        .slot           (slot),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .status         (status),
        .granted_slot   (granted_slot),
        .slot_is_free   (slot_is_free),
        .busy_map       (busy_map),
        .inflight_count (inflight_count)
    );

    // The count always matches the mask it describes.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (inflight_count == CNT_W'($countones(busy_map))))
        else $error("inflight_count does not match busy_map");

    // A free answer is only given by a successful query.
    a_free_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && slot_is_free) |-> (status == 1'b0))
        else $error("slot_is_free set on an error response");

    // Failed commands never report a granted slot.
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status) |-> (granted_slot == '0))
        else $error("granted_slot nonzero on an error response");

    // No new command is taken while a response is pending.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cmd_stall)
        else $error("command channel open while a response is pending");

    // An accepted command closes the command channel on the next cycle.
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("command channel still open after an accept");

endmodule
`default_nettype wire

### sim/command_slot_bitmap_allocator_tb.sv
// ============================================================================
// command_slot_bitmap_allocator_tb
// Self-checking bench for the command slot allocator. A clocked driver feeds
// commands from a queue, and a clocked monitor predicts each accepted command
// against a private copy of the free map and compares every response field.
// ============================================================================
module command_slot_bitmap_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import csba_pkg::*;

    localparam int          DRAIN_CYCLES = 12;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [31:0] ALL_SLOTS    = 32'hFFFF_FFFF;

    // One command as the driver offers it on the command channel.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
    } slot_cmd_t;

    // One response as the block should return it.
    typedef struct packed {
        logic                 status;
        logic [SLOT_W-1:0]    granted;
        logic                 is_free;
        logic [MAX_SLOTS-1:0] mask;
        logic [CNT_W-1:0]     count;
    } slot_rsp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cmd_valid = 1'b0;
    wire                  cmd_stall;
    logic [OP_W-1:0]      opcode = OP_ALLOC;
    logic [SLOT_W-1:0]    slot = '0;
    wire                  rsp_valid;
    wire                  rsp_stall;
    wire                  status;
    wire [SLOT_W-1:0]     granted_slot;
    wire                  slot_is_free;
    wire [MAX_SLOTS-1:0]  busy_map;
    wire [CNT_W-1:0]      inflight_count;
    logic                 cfg_valid = 1'b0;
    wire                  cfg_ready;
    logic [CNT_W-1:0]     cfg_data = '0;

    // The response stall is the random stall pattern or the long hold-off.
    logic stall_rand = 1'b0;
    logic hold_off = 1'b0;
    logic hold_go = 1'b0;
    assign rsp_stall = stall_rand | hold_off;

    // Pacing knobs, in percent of cycles.
    int send_idle_pct = 0;
    int stall_pct = 0;

    // Commands waiting to be offered, and responses waiting to arrive.
    slot_cmd_t pending_cmds[$];
    slot_rsp_t expected_rsps[$];

    // Private copy of the block state: the free map and the slot count register.
    logic [MAX_SLOTS-1:0] free_bits = ALL_SLOTS;
    logic [CNT_W-1:0]     slot_limit = SLOT_COUNT_RST;

    int cmds_offered = 0;
    int cmds_accepted = 0;
    int rsps_checked = 0;
    int settings_used = 0;
    int errors = 0;

    command_slot_bitmap_allocator uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .opcode         (opcode),
        .slot           (slot),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .granted_slot   (granted_slot),
        .slot_is_free   (slot_is_free),
        .busy_map       (busy_map),
        .inflight_count (inflight_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Hard limit on the run; far beyond the slowest legal schedule.
    initial
    begin
        #2ms;
        $display("%0t: timeout with %0d responses still expected", $time,
                 expected_rsps.size());
        $display("TEST FAILED");
        $finish;
    end

    // Effective slot count: zero or anything above the map size disables the block.
    function automatic logic [CNT_W-1:0] usable_count(input logic [CNT_W-1:0] cnt);
        if (cnt == '0 || cnt > CNT_W'(MAX_SLOTS))
        begin
            return '0;
        end
        return cnt;
    endfunction

    // Applies one command to the private free map and returns the response the
    // block must give for it. The in-flight mask is taken after the update.
    function automatic slot_rsp_t apply_command(input slot_cmd_t c);
        slot_rsp_t            r;
        logic [CNT_W-1:0]     n;
        logic [MAX_SLOTS-1:0] usable;
        logic [MAX_SLOTS-1:0] cand;
        r = '0;
        n = usable_count(slot_limit);
        usable = (n >= CNT_W'(MAX_SLOTS)) ? ALL_SLOTS : ((32'd1 << n) - 32'd1);
        case (c.op)
            OP_ALLOC:
            begin
                // Only slots below the count are candidates, stale bits above are ignored.
                cand = free_bits & usable;
                if (cand == '0)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    for (int i = MAX_SLOTS - 1; i >= 0; i--)
                    begin
                        if (cand[i])
                        begin
                            r.granted = SLOT_W'(i);
                        end
                    end
                    free_bits[r.granted] = 1'b0;
                end
            end
            OP_RELEASE:
            begin
                if ({1'b0, c.slot} >= n || free_bits[c.slot])
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    free_bits[c.slot] = 1'b1;
                end
            end
            OP_RESET:
            begin
                if (n == '0)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    free_bits = usable;
                end
            end
            OP_QUERY:
            begin
                if ({1'b0, c.slot} >= n)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    r.is_free = free_bits[c.slot];
                end
            end
        endcase
        r.mask = usable & ~free_bits;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            r.count = r.count + CNT_W'(r.mask[i]);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // Driver. A new item is chosen only once the previous one was taken, so the
    // payload stays put while the block stalls and valid never looks at stall.
    always @(negedge clk)
    begin
        slot_cmd_t nxt;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (!(cmd_valid && cmds_accepted != cmds_offered))
        begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = pending_cmds.pop_front();
                cmd_valid <= 1'b1;
                opcode    <= nxt.op;
                slot      <= nxt.slot;
                cmds_offered++;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Random part of the response stall.
    always @(negedge clk)
    begin
        stall_rand <= ($urandom_range(0, 99) < stall_pct);
    end

    // Long receiver hold-off, counted in its own process. The sender keeps
    // offering meanwhile, so the block fills and stalls its command channel.
    initial
    begin
        wait (hold_go);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    // Monitor. Responses are checked before the command taken at the same edge
    // is predicted; the queue order makes the two independent anyway.
    always @(posedge clk)
    begin
        slot_rsp_t exp_r;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, got status %0b slot %0d",
                             $time, status, granted_slot);
                    errors++;
                end
                else
                begin
                    exp_r = expected_rsps.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(status));
                    check_field("granted_slot", 32'(exp_r.granted), 32'(granted_slot));
                    check_field("slot_is_free", 32'(exp_r.is_free), 32'(slot_is_free));
                    check_field("busy_map", exp_r.mask, busy_map);
                    check_field("inflight_count", 32'(exp_r.count), 32'(inflight_count));
                    rsps_checked++;
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                expected_rsps.push_back(apply_command('{op: opcode, slot: slot}));
                cmds_accepted++;
            end
        end
    end

    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] s);
        pending_cmds.push_back('{op: op, slot: s});
    endtask

    // Waits until every queued item was taken and answered, then lets the
    // pipeline settle.
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || cmds_accepted != cmds_offered ||
               expected_rsps.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes the slot count register; the caller guarantees the block is idle.
    task automatic write_slot_count(input logic [CNT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        slot_limit = value;
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Pacing modes: none, sender idle, receiver stall, both.
    task automatic set_pace(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 68;
                stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct = 68;
            end
            default:
            begin
                send_idle_pct = 26;
                stall_pct = 26;
            end
        endcase
    endtask

    // Random commands shaped like real traffic: allocations balanced by
    // releases that mostly hit slots that are likely busy, with some queries,
    // an occasional map reset, and a share of arbitrary slot numbers.
    task automatic queue_random_cmds(input int items);
        int               busy_guess;
        int               pick;
        int               n;
        logic [SLOT_W-1:0] s;
        busy_guess = 0;
        n = int'(usable_count(slot_limit));
        for (int k = 0; k < items; k++)
        begin
            pick = $urandom_range(0, 99);
            s = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
            if (pick < 45)
            begin
                push_cmd(OP_ALLOC, s);
                if (busy_guess < n)
                begin
                    busy_guess++;
                end
            end
            else if (pick < 75)
            begin
                if (n > 0 && $urandom_range(0, 9) < 8)
                begin
                    s = SLOT_W'($urandom_range(0, ((busy_guess > 0) ? busy_guess : n) - 1));
                end
                push_cmd(OP_RELEASE, s);
                if (busy_guess > 0)
                begin
                    busy_guess--;
                end
            end
            else if (pick < 93)
            begin
                if (n > 0 && $urandom_range(0, 9) < 7)
                begin
                    s = SLOT_W'($urandom_range(0, n - 1));
                end
                push_cmd(OP_QUERY, s);
            end
            else
            begin
                push_cmd(OP_RESET, s);
                busy_guess = 0;
            end
        end
    endtask

    // One random phase: new count, optional map reset, pacing, optional hold-off and traffic.
    task automatic run_phase(input logic [CNT_W-1:0] count, input bit clear_map,
                             input int mode, input int items, input bit with_hold);
        wait_idle();
        write_slot_count(count);
        set_pace(mode);
        if (clear_map)
        begin
            push_cmd(OP_RESET, '0);
        end
        if (with_hold)
        begin
            hold_go = 1'b1;
        end
        queue_random_cmds(items);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset count of 32: first-fit allocation,
        // query of free and busy slots, release and double release, top slot.
        set_pace(0);
        push_cmd(OP_QUERY, 5'd0);
        push_cmd(OP_ALLOC, 5'd31);
        push_cmd(OP_ALLOC, 5'd0);
        push_cmd(OP_QUERY, 5'd1);
        push_cmd(OP_QUERY, 5'd31);
        push_cmd(OP_RELEASE, 5'd0);
        push_cmd(OP_RELEASE, 5'd0);
        push_cmd(OP_RELEASE, 5'd31);
        push_cmd(OP_ALLOC, 5'd0);
        push_cmd(OP_RESET, 5'd31);
        wait_idle();

        // One usable slot: the pool runs dry and high slots are out of range.
        write_slot_count(6'd1);
        push_cmd(OP_RESET, 5'd0);
        push_cmd(OP_ALLOC, 5'd0);
        push_cmd(OP_ALLOC, 5'd0);
        push_cmd(OP_RELEASE, 5'd1);
        push_cmd(OP_QUERY, 5'd31);
        push_cmd(OP_QUERY, 5'd0);
        push_cmd(OP_RELEASE, 5'd0);
        wait_idle();

        // A count of zero, and one above the map size, both disable the block.
        write_slot_count(6'd0);
        push_cmd(OP_ALLOC, 5'd0);
        push_cmd(OP_RELEASE, 5'd0);
        push_cmd(OP_RESET, 5'd0);
        push_cmd(OP_QUERY, 5'd0);
        wait_idle();
        write_slot_count(6'd63);
        push_cmd(OP_ALLOC, 5'd0);
        push_cmd(OP_QUERY, 5'd5);

        // Random phases. The count of 5 follows 17 without a map reset, so
        // stale free bits above the count must never be handed out.
        run_phase(6'd32, 1'b1, 0, 160, 1'b1);
        run_phase(6'd17, 1'b1, 1, 140, 1'b0);
        run_phase(6'd5,  1'b0, 2, 120, 1'b0);
        run_phase(6'd33, 1'b0, 3, 40,  1'b0);
        run_phase(6'd31, 1'b1, 0, 160, 1'b0);
        run_phase(6'd1,  1'b1, 1, 80,  1'b0);
        run_phase(6'd63, 1'b0, 2, 30,  1'b0);
        run_phase(6'd24, 1'b0, 3, 140, 1'b0);
        run_phase(6'd2,  1'b1, 0, 80,  1'b0);
        run_phase(6'd32, 1'b1, 3, 200, 1'b0);
        wait_idle();

        $display("Checked %0d responses for %0d commands over %0d slot-count writes,",
                 rsps_checked, cmds_accepted, settings_used);
        $display("with idle and stall pacing and one long receiver hold-off.");
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
